// ----- hw/rtl/drfr_pkg.sv -----
// ----------------------------------------------------------------------------
// drfr_pkg
// Shared constants, codes and controller/datapath interface types of the
// dual-format frame receiver.
// ----------------------------------------------------------------------------
package drfr_pkg;

	localparam int FRAME_DEPTH = 64;
	localparam int CAP_RESULTS = 64;
	localparam int ADDR_W      = $clog2(FRAME_DEPTH);
	localparam int CNT_W       = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int LIMIT_CAP   = (FRAME_DEPTH < CAP_RESULTS) ? FRAME_DEPTH : CAP_RESULTS;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIN_HEAD_FIRST  = 3'd0,
		REG_BIN_HEAD_SECOND = 3'd1,
		REG_BIN_TAIL_FIRST  = 3'd2,
		REG_BIN_TAIL_SECOND = 3'd3,
		REG_TEXT_HEAD       = 3'd4,
		REG_TEXT_TAIL_FIRST = 3'd5,
		REG_TEXT_TAIL_SEC   = 3'd6,
		REG_MAX_FRAME_LEN   = 3'd7
	} cfg_reg_t;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_HEAD_ERR = 2'd1;
	localparam logic [1:0] ST_TAIL_ERR = 2'd2;

	// Frame kinds.
	localparam logic KIND_BIN  = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	// Frame store read address selection.
	typedef enum logic [2:0] {
		RD_ONE,
		RD_TWO,
		RD_LEN3,
		RD_LEN4,
		RD_WORD_HI,
		RD_WORD_LO,
		RD_SCAN_NEXT,
		RD_CHAR
	} rd_sel_t;

	// Kind of result loaded into the output register.
	typedef enum logic [1:0] {
		EM_ERR,
		EM_EMPTY,
		EM_WORD,
		EM_CHAR
	} emit_sel_t;

	typedef struct packed {
		logic       open_frame;
		logic       store_byte;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       cap_len;
		logic       cap_hi;
		logic       scan_init;
		logic       scan_inc;
		logic       item_init;
		logic       item_text;
		logic       item_inc;
		logic       emit;
		emit_sel_t  emit_sel;
		logic       kind;
		logic [1:0] err_status;
	} dp_cmd_t;

	typedef struct packed {
		logic byte_bin_head;
		logic byte_text_head;
		logic byte_bin_close;
		logic byte_text_close;
		logic overflow;
		logic cnt_lt3;
		logic rd_eq_head2;
		logic rd_eq_tail1;
		logic rd_eq_tail2;
		logic rd_eq_ttail1;
		logic rd_eq_ttail2;
		logic len_fits;
		logic chk_fits;
		logic total_zero;
		logic item_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- hw/rtl/dual_format_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// dual_format_frame_receiver_core
// Receives bytes, assembles binary or text frames in a frame store, checks
// header and trailer bytes and emits the frame contents as a result burst.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid / in_stall  rx_byte
//  result    out        out_valid/out_stall  frame_kind, status, has_data,
//                                            payload, item_count, last
//  config    in         cfg_we               cfg_index, cfg_data
//
// A byte that opens, extends or drops a frame is accepted without a stall.
// A closing byte starts a check that reads the frame store: a binary frame's
// second header byte, length, both trailer bytes and then each word; a text
// frame's end marker scan and then each character. An overflow emits an error.
// Input stalls during the check and burst; output stalls hold the sequence.
// Reset returns the receiver to idle and restores the register defaults.
// ----------------------------------------------------------------------------
module dual_format_frame_receiver_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           frame_kind,
	output logic [1:0]                     status,
	output logic                           has_data,
	output logic [15:0]                    payload,
	output logic [5:0]                     item_count,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [drfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import drfr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	drfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	drfr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.stat       (stat),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.frame_kind (frame_kind),
		.status     (status),
		.has_data   (has_data),
		.payload    (payload),
		.item_count (item_count),
		.last       (last)
	);

endmodule

// ----- hw/rtl/drfr_ram.sv -----
// ----------------------------------------------------------------------------
// drfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module drfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/drfr_dp.sv -----
// ----------------------------------------------------------------------------
// drfr_dp
// Datapath: configuration registers, byte counter, frame store, check
// registers, item counters and the output register.
// ----------------------------------------------------------------------------
module drfr_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [drfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic [7:0]                     rx_byte,
	input  drfr_pkg::dp_cmd_t              cmd,
	output drfr_pkg::dp_stat_t             stat,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic                           frame_kind,
	output logic [1:0]                     status,
	output logic                           has_data,
	output logic [15:0]                    payload,
	output logic [5:0]                     item_count,
	output logic                           last
);
	import drfr_pkg::*;

	logic [7:0]       bin_head_first_q, bin_head_second_q, bin_tail_first_q, bin_tail_second_q;
	logic [7:0]       text_head_q, text_tail_first_q, text_tail_second_q;
	logic [CNT_W-1:0] max_frame_len_q;

	logic [CNT_W-1:0] cnt_q, cnt_next, limit;
	logic [7:0]       len_q, hi_q;
	logic [CNT_W-1:0] p_q;
	logic [5:0]       j_q, total_q;
	logic             out_valid_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        rdata;
	logic [8:0]        addr_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_head_first_q   <= 8'hFF;
			bin_head_second_q  <= 8'hAA;
			bin_tail_first_q   <= 8'h55;
			bin_tail_second_q  <= 8'hFE;
			text_head_q        <= 8'h40;
			text_tail_first_q  <= 8'h24;
			text_tail_second_q <= 8'h23;
			max_frame_len_q    <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BIN_HEAD_FIRST:  bin_head_first_q   <= cfg_data;
				REG_BIN_HEAD_SECOND: bin_head_second_q  <= cfg_data;
				REG_BIN_TAIL_FIRST:  bin_tail_first_q   <= cfg_data;
				REG_BIN_TAIL_SECOND: bin_tail_second_q  <= cfg_data;
				REG_TEXT_HEAD:       text_head_q        <= cfg_data;
				REG_TEXT_TAIL_FIRST: text_tail_first_q  <= cfg_data;
				REG_TEXT_TAIL_SEC:   text_tail_second_q <= cfg_data;
				REG_MAX_FRAME_LEN:   max_frame_len_q    <= cfg_data[CNT_W-1:0];
				default:             max_frame_len_q    <= max_frame_len_q;
			endcase
		end
	end

	assign cnt_next = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 7'd1;
	assign limit    = (max_frame_len_q > CNT_W'(LIMIT_CAP)) ? CNT_W'(LIMIT_CAP) : max_frame_len_q;

	// Byte counter and per-frame check registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			p_q     <= '0;
			j_q     <= '0;
			total_q <= '0;
		end else begin
			if (cmd.open_frame) begin
				cnt_q <= 7'd1;
			end else if (cmd.store_byte) begin
				cnt_q <= cnt_next;
			end
			if (cmd.scan_init) begin
				p_q <= 7'd1;
			end else if (cmd.scan_inc) begin
				p_q <= p_q + 7'd1;
			end
			if (cmd.item_init) begin
				j_q     <= '0;
				total_q <= cmd.item_text ? 6'(p_q - 7'd1) : len_q[6:1];
			end else if (cmd.item_inc) begin
				j_q <= j_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_len) begin
			len_q <= rdata;
		end
		if (cmd.cap_hi) begin
			hi_q <= rdata;
		end
	end

	// Frame store.
	assign ram_we    = cmd.open_frame ||
		(cmd.store_byte && ({2'b00, cnt_q} < 9'(FRAME_DEPTH)));
	assign ram_waddr = cmd.open_frame ? '0 : cnt_q[ADDR_W-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ONE:       addr_full = 9'd1;
			RD_TWO:       addr_full = 9'd2;
			RD_LEN3:      addr_full = {1'b0, rdata} + 9'd3;
			RD_LEN4:      addr_full = {1'b0, len_q} + 9'd4;
			RD_WORD_HI:   addr_full = {2'b00, j_q, 1'b0} + 9'd3;
			RD_WORD_LO:   addr_full = {2'b00, j_q, 1'b0} + 9'd4;
			RD_SCAN_NEXT: addr_full = {2'b00, p_q} + 9'd1;
			RD_CHAR:      addr_full = {3'b000, j_q} + 9'd1;
			default:      addr_full = 9'd1;
		endcase
	end
	assign ram_raddr = addr_full[ADDR_W-1:0];

	drfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx_byte),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Status toward the controller.
	always_comb begin
		stat.byte_bin_head   = (rx_byte == bin_head_first_q);
		stat.byte_text_head  = (rx_byte == text_head_q);
		stat.byte_bin_close  = (rx_byte == bin_tail_second_q);
		stat.byte_text_close = (rx_byte == text_tail_second_q);
		stat.overflow        = (cnt_next >= limit);
		stat.cnt_lt3         = (cnt_q < 7'd3);
		stat.rd_eq_head2     = (rdata == bin_head_second_q);
		stat.rd_eq_tail1     = (rdata == bin_tail_first_q);
		stat.rd_eq_tail2     = (rdata == bin_tail_second_q);
		stat.rd_eq_ttail1    = (rdata == text_tail_first_q);
		stat.rd_eq_ttail2    = (rdata == text_tail_second_q);
		stat.len_fits        = (({1'b0, rdata} + 9'd4) < {2'b00, cnt_q});
		stat.chk_fits        = (({1'b0, p_q} + 8'd1) < {1'b0, cnt_q});
		stat.total_zero      = (total_q == '0);
		stat.item_last       = (({1'b0, j_q} + 7'd1) == {1'b0, total_q});
		stat.out_free        = !out_valid_q || !out_stall;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			frame_kind <= cmd.kind;
			unique case (cmd.emit_sel)
				EM_ERR: begin
					status     <= cmd.err_status;
					has_data   <= 1'b0;
					payload    <= '0;
					item_count <= '0;
					last       <= 1'b1;
				end
				EM_EMPTY: begin
					status     <= ST_OK;
					has_data   <= 1'b0;
					payload    <= '0;
					item_count <= '0;
					last       <= 1'b1;
				end
				EM_WORD: begin
					status     <= ST_OK;
					has_data   <= 1'b1;
					payload    <= {hi_q, rdata};
					item_count <= total_q;
					last       <= stat.item_last;
				end
				EM_CHAR: begin
					status     <= ST_OK;
					has_data   <= 1'b1;
					payload    <= {8'h00, rdata};
					item_count <= total_q;
					last       <= stat.item_last;
				end
				default: begin
					status     <= cmd.err_status;
					has_data   <= 1'b0;
					payload    <= '0;
					item_count <= '0;
					last       <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/drfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// drfr_ctrl
// Controller: receive mode, frame check sequence and result burst.
// ----------------------------------------------------------------------------
module drfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  drfr_pkg::dp_stat_t stat,
	output drfr_pkg::dp_cmd_t  cmd
);
	import drfr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RXB,
		S_RXT,
		S_B_GO,
		S_B_HEAD,
		S_B_LEN,
		S_B_T1,
		S_B_T2,
		S_B_START,
		S_B_RD,
		S_B_HI,
		S_B_LO,
		S_T_GO,
		S_T_SCAN,
		S_T_CHK,
		S_T_START,
		S_T_RD,
		S_T_CHAR,
		S_ERR
	} state_t;

	state_t     state_q, state_d;
	logic       err_kind_q, err_kind_d;
	logic [1:0] err_status_q, err_status_d;
	logic       in_fire;

	assign in_stall = !((state_q == S_IDLE) || (state_q == S_RXB) || (state_q == S_RXT));
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		state_d      = state_q;
		err_kind_d   = err_kind_q;
		err_status_d = err_status_q;
		cmd          = '0;
		cmd.rd_sel   = RD_ONE;
		cmd.emit_sel = EM_ERR;
		cmd.kind     = err_kind_q;
		cmd.err_status = err_status_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (stat.byte_bin_head) begin
						cmd.open_frame = 1'b1;
						state_d        = S_RXB;
					end else if (stat.byte_text_head) begin
						cmd.open_frame = 1'b1;
						state_d        = S_RXT;
					end
				end
			end
			S_RXB: begin
				if (in_fire) begin
					cmd.store_byte = 1'b1;
					if (stat.byte_bin_close) begin
						state_d = S_B_GO;
					end else if (stat.overflow) begin
						err_kind_d   = KIND_BIN;
						err_status_d = ST_TAIL_ERR;
						state_d      = S_ERR;
					end
				end
			end
			S_RXT: begin
				if (in_fire) begin
					cmd.store_byte = 1'b1;
					if (stat.byte_text_close) begin
						state_d = S_T_GO;
					end else if (stat.overflow) begin
						err_kind_d   = KIND_TEXT;
						err_status_d = ST_TAIL_ERR;
						state_d      = S_ERR;
					end
				end
			end
			S_B_GO: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_ONE;
				state_d    = S_B_HEAD;
			end
			S_B_HEAD: begin
				err_kind_d = KIND_BIN;
				if (!stat.rd_eq_head2) begin
					err_status_d = ST_HEAD_ERR;
					state_d      = S_ERR;
				end else if (stat.cnt_lt3) begin
					err_status_d = ST_TAIL_ERR;
					state_d      = S_ERR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_TWO;
					state_d    = S_B_LEN;
				end
			end
			S_B_LEN: begin
				cmd.cap_len = 1'b1;
				if (!stat.len_fits) begin
					err_status_d = ST_TAIL_ERR;
					state_d      = S_ERR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEN3;
					state_d    = S_B_T1;
				end
			end
			S_B_T1: begin
				if (!stat.rd_eq_tail1) begin
					err_status_d = ST_TAIL_ERR;
					state_d      = S_ERR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEN4;
					state_d    = S_B_T2;
				end
			end
			S_B_T2: begin
				if (!stat.rd_eq_tail2) begin
					err_status_d = ST_TAIL_ERR;
					state_d      = S_ERR;
				end else begin
					cmd.item_init = 1'b1;
					state_d       = S_B_START;
				end
			end
			S_B_START: begin
				cmd.kind = KIND_BIN;
				if (!stat.total_zero) begin
					state_d = S_B_RD;
				end else if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_EMPTY;
					state_d      = S_IDLE;
				end
			end
			S_B_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_WORD_HI;
				state_d    = S_B_HI;
			end
			S_B_HI: begin
				cmd.cap_hi = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_WORD_LO;
				state_d    = S_B_LO;
			end
			S_B_LO: begin
				cmd.kind = KIND_BIN;
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_WORD;
					cmd.item_inc = 1'b1;
					state_d      = stat.item_last ? S_IDLE : S_B_RD;
				end
			end
			S_T_GO: begin
				cmd.scan_init = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_ONE;
				state_d       = S_T_SCAN;
			end
			S_T_SCAN: begin
				err_kind_d   = KIND_TEXT;
				err_status_d = ST_TAIL_ERR;
				// Reads the byte at the scan index; stop at the first end marker.
				if (stat.rd_eq_ttail1) begin
					if (stat.chk_fits) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_SCAN_NEXT;
						state_d    = S_T_CHK;
					end else begin
						state_d = S_ERR;
					end
				end else if (!stat.chk_fits) begin
					state_d = S_ERR;
				end else begin
					cmd.scan_inc = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RD_SCAN_NEXT;
				end
			end
			S_T_CHK: begin
				if (!stat.rd_eq_ttail2) begin
					state_d = S_ERR;
				end else begin
					cmd.item_init = 1'b1;
					cmd.item_text = 1'b1;
					state_d       = S_T_START;
				end
			end
			S_T_START: begin
				cmd.kind = KIND_TEXT;
				if (!stat.total_zero) begin
					state_d = S_T_RD;
				end else if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_EMPTY;
					state_d      = S_IDLE;
				end
			end
			S_T_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CHAR;
				state_d    = S_T_CHAR;
			end
			S_T_CHAR: begin
				cmd.kind = KIND_TEXT;
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_CHAR;
					cmd.item_inc = 1'b1;
					state_d      = stat.item_last ? S_IDLE : S_T_RD;
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_ERR;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			err_kind_q   <= KIND_BIN;
			err_status_q <= ST_OK;
		end else begin
			state_q      <= state_d;
			err_kind_q   <= err_kind_d;
			err_status_q <= err_status_d;
		end
	end

	// A result is only loaded into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result loaded into an occupied output register");

	// No byte is taken while a result burst is being produced.
	a_emit_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> in_stall)
		else $error("input accepted during a result burst");

	// Frame store reads never coincide with a byte being stored.
	a_no_rd_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !(cmd.store_byte || cmd.open_frame))
		else $error("frame store read while a byte is written");

	// A data result without a following item ends the burst.
	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && (cmd.emit_sel == EM_WORD || cmd.emit_sel == EM_CHAR) &&
		 stat.item_last) |=> (state_q == S_IDLE))
		else $error("burst did not end after its last item");

endmodule
